/* rtl/core/ins_sort_pkg.sv */
package ins_sort_pkg;

   // Element width and default store depth
   localparam int DATA_WIDTH       = 32;
   localparam int CAPACITY_DEFAULT = 64;

   // Controller states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic insert;     // insert the request value into the cell row
      logic mark_drop;  // row is full: note a dropped element
      logic emit;       // shift one entry out to the result register
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;       // every cell holds an entry
      logic last_one;   // exactly one entry left to emit
   } dp_status_type;

endpackage

/* rtl/core/ins_sort_ctrl.sv */
module ins_sort_ctrl
   import ins_sort_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          end_of_list,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      busy          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.insert    = !status.full;
               cmd.mark_drop = status.full;
               if (end_of_list) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            busy     = 1'b1;
            cmd.emit = 1'b1;
            if (status.last_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/ins_sort_datapath.sv */
module ins_sort_datapath
   import ins_sort_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   input  logic signed [DATA_WIDTH-1:0]  value,
   output dp_status_type                 status,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_sorted_value,
   output logic                          rsp_last_out,
   output logic                          rsp_overflow
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          drop_ff;
   logic          drop_in;

   logic signed [DATA_WIDTH-1:0] store_ff [CAPACITY];
   logic signed [DATA_WIDTH-1:0] store_in [CAPACITY];

   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] le;

   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff;
   logic                         rsp_last_ff;
   logic                         rsp_overflow_ff;

   assign status.full     = (count_ff == CW'(CAPACITY));
   assign status.last_one = (count_ff == CW'(1));

   // Compare-and-shift cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                         prev_le;
      logic                         prev_gt;
      logic signed [DATA_WIDTH-1:0] prev_val;
      logic signed [DATA_WIDTH-1:0] next_val;

      assign valid[i] = (CW'(i) < count_ff);
      assign le[i]    = valid[i] && (store_ff[i] <= value);

      if (i == 0) begin : g_first
         assign prev_le  = 1'b1;
         assign prev_gt  = 1'b0;
         assign prev_val = store_ff[i];
      end else begin : g_rest
         assign prev_le  = le[i-1];
         assign prev_gt  = valid[i-1] && !le[i-1];
         assign prev_val = store_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign next_val = store_ff[i];
      end else begin : g_below
         assign next_val = store_ff[i+1];
      end

      // Take the neighbor below, the new value, or shift down on emit
      always_comb begin
         priority if (cmd.insert && prev_gt) begin
            store_in[i] = prev_val;
         end else if (cmd.insert && !le[i] && prev_le) begin
            store_in[i] = value;
         end else if (cmd.emit) begin
            store_in[i] = next_val;
         end else begin
            store_in[i] = store_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         store_ff[i] <= store_in[i];
      end
   end

   // Fill count and drop flag
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      priority if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.mark_drop) begin
         drop_in = 1'b1;
      end else if (cmd.emit) begin
         count_in = count_ff - CW'(1);
         if (status.last_one) begin
            drop_in = 1'b0;
         end
      end else begin
         // hold count and flag
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   // Result register, loaded from the bottom cell
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff    <= store_ff[0];
         rsp_last_ff     <= status.last_one;
         rsp_overflow_ff <= drop_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

/* rtl/core/insertion_sorter_core.sv */
// Streaming insertion sorter for signed 32-bit values. A request is taken on
// any clock edge with start high and busy low, one per cycle: a row of
// CAPACITY compare-and-shift cells places each value after any equal
// entries. Values arriving with the row full are dropped and every
// result of that list carries rsp_overflow. The request with end_of_list set
// raises busy until all stored entries (1 to CAPACITY) have left; the
// entries leave the bottom cell one per cycle in ascending order and each
// shows on the rsp_ ports for exactly one cycle under rsp_valid, registered
// in the cycle after its shift, with rsp_last_out on the final one.
// The receiver cannot stall and must take every result as it appears.
module insertion_sorter_core
   import ins_sort_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         req_end_of_list,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                         rsp_last_out,
   output logic                         rsp_overflow
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence requests and emission
   ins_sort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .end_of_list (req_end_of_list),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Cell row and result register
   ins_sort_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .value            (req_value),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
